// ===== hdl/gamma_graymap_pixel_encoder_core_assert.svh =====
// Assertion macros shared by gg_queue and gg_back.
// Define NO_ASSERTIONS to compile them out.
`ifndef GAMMA_GRAYMAP_PIXEL_ENCODER_CORE_ASSERT_SVH
`define GAMMA_GRAYMAP_PIXEL_ENCODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/gg_pkg.sv =====
// Shared constants, types and curve-table functions for the gray-map encoder.
// No dependencies.
`timescale 1ns / 1ps
package gg_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int CURVE_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH     = 4;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GRAY      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 8'd1;

    localparam logic FMT_INT   = 1'b0;
    localparam logic FMT_FIXED = 1'b1;

    localparam logic [15:0] MAX_GRAY_RST = 16'd255;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef struct packed {
        logic [63:0]        m;
        logic signed [31:0] e;
    } t_pflt;

    // normalise mantissa into [2^30, 2^31)
    function automatic t_pflt pf_make(logic [63:0] m, logic signed [31:0] e);
        t_pflt              r;
        logic [63:0]        mm;
        logic signed [31:0] ee;
        mm = m;
        ee = e;
        while (mm >= (Q30_ONE << 1)) begin
            mm = mm >> 1;
            ee = ee + 32'sd1;
        end
        while (mm < Q30_ONE) begin
            mm = mm << 1;
            ee = ee - 32'sd1;
        end
        r.m = mm;
        r.e = ee;
        return r;
    endfunction

    function automatic t_pflt pf_mul(t_pflt a, t_pflt b);
        return pf_make((a.m * b.m) >> 30, a.e + b.e);
    endfunction

    function automatic t_pflt pf_pow9(t_pflt a);
        t_pflt a2, a4, a8;
        a2 = pf_mul(a, a);
        a4 = pf_mul(a2, a2);
        a8 = pf_mul(a4, a4);
        return pf_mul(a8, a);
    endfunction

    function automatic t_pflt pf_pow20(t_pflt a);
        t_pflt a2, a4, a5, a10;
        a2  = pf_mul(a, a);
        a4  = pf_mul(a2, a2);
        a5  = pf_mul(a4, a);
        a10 = pf_mul(a5, a5);
        return pf_mul(a10, a10);
    endfunction

    function automatic logic pf_le(t_pflt a, t_pflt b);
        if (a.e != b.e) begin
            return a.e < b.e;
        end
        return a.m <= b.m;
    endfunction

    // Q30 entry k of (k/d)^0.45: largest y with (y/2^30)^20 <= (k/d)^9
    function automatic logic [30:0] curve_entry(int k, int d);
        t_pflt       d9, rhs, lhs;
        logic [63:0] lo, hi, mid;
        if (k == 0) begin
            return 31'd0;
        end
        if (k == d) begin
            return 31'(Q30_ONE);
        end
        d9  = pf_pow9(pf_make(64'(d), 32'sd30));
        rhs = pf_pow9(pf_make(64'(k), 32'sd30));
        lo  = 64'd0;
        hi  = Q30_ONE;
        while (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            lhs = pf_mul(pf_pow20(pf_make(mid, 32'sd0)), d9);
            if (pf_le(lhs, rhs)) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return 31'(lo);
    endfunction

endpackage

// ===== hdl/gg_sample_if.sv =====
// Input sample channel: valid/ready plus one sample request.
// Depends on nothing.
`timescale 1ns / 1ps
interface gg_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;
    logic               final_sample;

    modport source (output valid, output sample_value, output final_sample, input ready);
    modport sink   (input valid, input sample_value, input final_sample, output ready);
endinterface

// ===== hdl/gg_byte_if.sv =====
// Output byte channel: valid/ready plus one byte request.
// Depends on nothing.
`timescale 1ns / 1ps
interface gg_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       image_end;

    modport source (output valid, output data_byte, output last_byte, output image_end,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input image_end,
                    output ready);
endinterface

// ===== hdl/gg_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on gg_pkg.
`timescale 1ns / 1ps
interface gg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gg_pkg::CFG_IDX_W-1:0]    index;
    logic [gg_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/gamma_graymap_pixel_encoder_core.sv =====
// Gray-map pixel encoder with Rec.709 gamma curve: top level.
// Depends on gg_pkg, the channel interfaces, gg_front, gg_queue, gg_back.
//
// Usage:
//   i_cfg    : register writes, always ready. Index 0 max gray (reset 255,
//              0 acts as 1), index 1 sample format (0 integer, 1 fixed
//              point). Write only while the block is idle.
//   i_sample : one sample per request, with a last-sample flag.
//   o_byte   : one byte per request; two bytes, high first, when max gray
//              exceeds 255. last_byte marks the sample's final byte,
//              image_end the final byte of the image.
// Throughput: one sample per cycle in one-byte mode while the receiver is
// ready; in two-byte mode the single byte output port takes two bytes per sample.
// Path from accept to the first byte: divider stages, the queue, eight curve
// stages, output register.
// Reset clears all valid state and loads the register defaults. When the
// receiver stalls, the output holds, the curve pipeline and the queue fill,
// then the front stops taking samples.
`timescale 1ns / 1ps
module gamma_graymap_pixel_encoder_core #(
    parameter int FRAC_BITS         = gg_pkg::FRAC_BITS_DEF,
    parameter int CURVE_TABLE_DEPTH = gg_pkg::CURVE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gg_cfg_if.sink     i_cfg,
    gg_sample_if.sink  i_sample,
    gg_byte_if.source  o_byte
);
    logic [15:0]        r_max_gray;
    logic               r_fmt;
    logic [15:0]        w_mg;
    logic               w_f_vld, w_f_fin, w_q_rdy;
    logic [FRAC_BITS:0] w_f_v;
    logic               w_q_vld, w_b_rdy;
    logic [FRAC_BITS+1:0] w_q_data;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gray <= gg_pkg::MAX_GRAY_RST;
            r_fmt      <= gg_pkg::FMT_INT;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == gg_pkg::CFG_MAX_GRAY) begin
                r_max_gray <= i_cfg.data[15:0];
            end else if (i_cfg.index == gg_pkg::CFG_SAMPLE_FORMAT) begin
                r_fmt <= i_cfg.data[0];
            end
        end
    end

    assign w_mg = (r_max_gray == 16'd0) ? 16'd1 : r_max_gray;

    gg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (i_sample),
        .i_mg    (w_mg),
        .i_fmt   (r_fmt),
        .o_vld   (w_f_vld),
        .o_v     (w_f_v),
        .o_fin   (w_f_fin),
        .i_rdy   (w_q_rdy)
    );

    gg_queue #(.WIDTH(FRAC_BITS + 2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_f_vld),
        .i_data  ({w_f_fin, w_f_v}),
        .o_rdy   (w_q_rdy),
        .o_vld   (w_q_vld),
        .o_data  (w_q_data),
        .i_rdy   (w_b_rdy)
    );

    gg_back #(
        .FRAC_BITS         (FRAC_BITS),
        .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_q_vld),
        .i_v     (w_q_data[FRAC_BITS:0]),
        .i_fin   (w_q_data[FRAC_BITS+1]),
        .o_rdy   (w_b_rdy),
        .i_mg    (w_mg),
        .o_byte  (o_byte)
    );
endmodule

// ===== hdl/gg_front.sv =====
// Front end: accepts samples, clamps them and normalises to a fraction v
// through a pipelined restoring divider. Depends on gg_pkg, gg_sample_if.
`timescale 1ns / 1ps
module gg_front #(
    parameter int FRAC_BITS = gg_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gg_sample_if.sink        i_smp,
    input  logic [15:0]      i_mg,
    input  logic             i_fmt,
    output logic             o_vld,
    output logic [FRAC_BITS:0] o_v,
    output logic             o_fin,
    input  logic             i_rdy
);
    localparam int NST = FRAC_BITS + 1;
    localparam logic [FRAC_BITS:0] V_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   r_byp;
    logic [NST-1:0]   r_fin;
    logic [15:0]      r_rem [NST];
    logic [FRAC_BITS:0] r_q [NST];

    logic [15:0]      n_rem [NST];
    logic [FRAC_BITS:0] n_q [NST];
    logic             n_byp;
    logic             w_en;
    logic [16:0]      w_two;
    logic             w_ge;

    assign w_en        = !r_vld[NST-1] || i_rdy;
    assign i_smp.ready = w_en;

    always_comb begin
        // classify the incoming sample and seed the divider
        n_rem[0] = 16'd0;
        n_q[0]   = '0;
        n_byp    = 1'b1;
        if (i_smp.sample_value <= 32'sd0) begin
            n_q[0] = '0;
        end else if (i_fmt == gg_pkg::FMT_INT) begin
            if (i_smp.sample_value >= $signed({16'd0, i_mg})) begin
                n_q[0] = V_ONE;
            end else begin
                n_rem[0] = i_smp.sample_value[15:0];
                n_byp    = 1'b0;
            end
        end else begin
            if (i_smp.sample_value >= $signed(32'(V_ONE))) begin
                n_q[0] = V_ONE;
            end else begin
                n_q[0] = i_smp.sample_value[FRAC_BITS:0];
            end
        end

        // one quotient bit per stage
        w_two = '0;
        w_ge  = 1'b0;
        for (int j = 1; j < NST; j++) begin
            w_two = {r_rem[j-1], 1'b0};
            w_ge  = w_two >= {1'b0, i_mg};
            if (r_byp[j-1]) begin
                n_rem[j] = r_rem[j-1];
                n_q[j]   = r_q[j-1];
            end else begin
                n_rem[j] = w_ge ? 16'(w_two - {1'b0, i_mg}) : w_two[15:0];
                n_q[j]   = {r_q[j-1][FRAC_BITS-1:0], w_ge};
            end
        end
    end

    // advance the divider pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_smp.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_byp <= {r_byp[NST-2:0], n_byp};
            r_fin <= {r_fin[NST-2:0], i_smp.final_sample};
            for (int j = 0; j < NST; j++) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
            end
        end
    end

    assign o_vld = r_vld[NST-1];
    assign o_v   = r_q[NST-1];
    assign o_fin = r_fin[NST-1];
endmodule

// ===== hdl/gg_queue.sv =====
// Short FIFO between the front end and the curve back end.
// Depends on gg_pkg and the assertion header.
`timescale 1ns / 1ps
`include "gamma_graymap_pixel_encoder_core_assert.svh"
module gg_queue #(
    parameter int WIDTH = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_rdy,
    output logic             o_vld,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_rdy
);
    localparam int DEPTH = gg_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_rdy  = r_count < CNT_W'(DEPTH);
    assign o_vld  = r_count != '0;
    assign o_data = r_mem[r_rd];
    assign w_push = i_vld && o_rdy;
    assign w_pop  = o_vld && i_rdy;

    // store the incoming request
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `GG_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `GG_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_push && !w_pop, r_count != '0)
    `GG_ASSERT_IMPL(a_ptrs_meet, i_clk, i_rst_n, r_count == '0, r_wr == r_rd)
endmodule

// ===== hdl/gg_back.sv =====
// Back end: Rec.709 curve (linear segment or interpolated power table),
// scaling by max gray, rounding and byte output. Depends on gg_pkg,
// gg_byte_if and the assertion header.
`timescale 1ns / 1ps
`include "gamma_graymap_pixel_encoder_core_assert.svh"
module gg_back #(
    parameter int FRAC_BITS         = gg_pkg::FRAC_BITS_DEF,
    parameter int CURVE_TABLE_DEPTH = gg_pkg::CURVE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [FRAC_BITS:0] i_v,
    input  logic               i_fin,
    output logic               o_rdy,
    input  logic [15:0]        i_mg,
    gg_byte_if.source          o_byte
);
    localparam int VW   = FRAC_BITS + 1;
    localparam int AW   = $clog2(CURVE_TABLE_DEPTH + 1);
    localparam int PW   = VW + AW;
    localparam int IW   = PW - FRAC_BITS;
    localparam int VMW  = VW + 16;
    localparam int PRW  = 31 + FRAC_BITS;
    localparam int RK   = 27;
    localparam logic [63:0] LIN_LIM = 64'd18 << FRAC_BITS;
    localparam logic [39:0] N_OFF   = 40'd99 << 30;
    localparam logic [57:0] RND_ADD = 58'd1000 << 30;
    localparam logic [20:0] RECIP   = 21'((64'd1 << RK) / 64'd125);

    typedef logic [30:0] t_tbl [0:CURVE_TABLE_DEPTH];

    function automatic t_tbl build_tbl();
        t_tbl t;
        for (int k = 0; k <= CURVE_TABLE_DEPTH; k++) begin
            t[k] = gg_pkg::curve_entry(k, CURVE_TABLE_DEPTH);
            if (k > 0 && t[k] < t[k-1]) begin
                t[k] = t[k-1];
            end
        end
        return t;
    endfunction

    localparam t_tbl CURVE_ROM = build_tbl();

    logic [7:0]  r_v;
    logic        w_en, w_out_free, w_take;

    // stage registers
    logic              r1_lin, r1_fin;
    logic [AW-1:0]     r1_a0, r1_a1;
    logic [FRAC_BITS-1:0] r1_fr;
    logic [VMW-1:0]    r1_vm;
    logic [30:0]       r2_t0, r2_t1;
    logic [FRAC_BITS-1:0] r2_fr;
    logic [16:0]       r2_wl, r3_wl, r4_wl, r5_wl, r6_wl, r7_wl;
    logic [5:0]        r_lin;
    logic [5:0]        r_fin;
    logic [30:0]       r3_t0;
    logic [PRW-1:0]    r3_prod;
    logic [41:0]       r4_n;
    logic [39:0]       r5_plo;
    logic [31:0]       r5_phi;
    logic [23:0]       r6_x, r7_x;
    logic [17:0]       r7_q;
    logic [15:0]       r8_w;
    logic              r8_fin;

    // combinational next values
    logic [PW-1:0]     n_p;
    logic [IW-1:0]     n_idx;
    logic [AW-1:0]     n_a0, n_a1;
    logic [FRAC_BITS-1:0] n_fr;
    logic [30:0]       n_pw;
    logic [39:0]       n_n2;
    logic [57:0]       n_a;
    logic [44:0]       n_xr;
    logic [23:0]       n_rem;
    logic [17:0]       n_wp;
    logic [17:0]       n_w;

    // output register
    logic              r_ovld, r_hi, r_ofin;
    logic [15:0]       r_ow;

    assign w_take     = o_byte.valid && o_byte.ready;
    assign w_out_free = !r_ovld || (o_byte.ready && !r_hi);
    assign w_en       = !r_v[7] || w_out_free;
    assign o_rdy      = w_en;

    // table address and interpolation fraction
    always_comb begin
        n_p   = PW'(i_v) * PW'(CURVE_TABLE_DEPTH);
        n_idx = n_p[PW-1:FRAC_BITS];
        if (n_idx >= IW'(CURVE_TABLE_DEPTH)) begin
            n_a0 = AW'(CURVE_TABLE_DEPTH);
            n_a1 = AW'(CURVE_TABLE_DEPTH);
            n_fr = '0;
        end else begin
            n_a0 = n_idx[AW-1:0];
            n_a1 = AW'(n_idx + 1'b1);
            n_fr = n_p[FRAC_BITS-1:0];
        end
    end

    // power branch arithmetic between registers
    always_comb begin
        n_pw  = r3_t0 + 31'(r3_prod >> FRAC_BITS);
        n_n2  = (r4_n > 42'(N_OFF)) ? 40'(r4_n - 42'(N_OFF)) : 40'd0;
        n_a   = ((58'(r5_phi) << 24) + 58'(r5_plo)) * 58'd2 + RND_ADD;
        n_xr  = 45'(r6_x) * 45'(RECIP);
        n_rem = r7_x - (24'(r7_q) * 24'd125);
        n_wp  = (n_rem >= 24'd125) ? r7_q + 18'd1 : r7_q;
        n_w   = r_lin[5] ? 18'(r7_wl) : n_wp;
    end

    // hold valid bits per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[6:0], i_vld};
        end
    end

    // advance the curve pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_lin  <= (64'(i_v) * 64'd1000) <= LIN_LIM;
            r1_fin  <= i_fin;
            r1_a0   <= n_a0;
            r1_a1   <= n_a1;
            r1_fr   <= n_fr;
            r1_vm   <= VMW'(i_v) * VMW'(i_mg);
            r2_t0   <= CURVE_ROM[r1_a0];
            r2_t1   <= CURVE_ROM[r1_a1];
            r2_fr   <= r1_fr;
            r2_wl   <= 17'(((r1_vm * VMW'(9)) + VMW'(1 << FRAC_BITS)) >> (FRAC_BITS + 1));
            r_lin   <= {r_lin[4:0], r1_lin};
            r_fin   <= {r_fin[4:0], r1_fin};
            r3_t0   <= r2_t0;
            r3_prod <= PRW'(r2_t1 - r2_t0) * PRW'(r2_fr);
            r3_wl   <= r2_wl;
            r4_n    <= 42'(n_pw) * 42'd1099;
            r4_wl   <= r3_wl;
            r5_plo  <= 40'(n_n2[23:0]) * 40'(i_mg);
            r5_phi  <= 32'(n_n2[39:24]) * 32'(i_mg);
            r5_wl   <= r4_wl;
            r6_x    <= n_a[57:34];
            r6_wl   <= r5_wl;
            r7_x    <= r6_x;
            r7_q    <= 18'(n_xr >> RK);
            r7_wl   <= r6_wl;
            r8_w    <= (n_w > 18'(i_mg)) ? i_mg : n_w[15:0];
            r8_fin  <= r_fin[5];
        end
    end

    // output register: high byte first in two-byte mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_hi   <= 1'b0;
        end else if (r_v[7] && w_out_free) begin
            r_ovld <= 1'b1;
            r_hi   <= i_mg > 16'd255;
        end else if (w_take) begin
            if (r_hi) begin
                r_hi <= 1'b0;
            end else begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v[7] && w_out_free) begin
            r_ow   <= r8_w;
            r_ofin <= r8_fin;
        end
    end

    assign o_byte.valid     = r_ovld;
    assign o_byte.data_byte = r_hi ? r_ow[15:8] : r_ow[7:0];
    assign o_byte.last_byte = !r_hi;
    assign o_byte.image_end = !r_hi && r_ofin;

    `GG_ASSERT_NEXT(a_low_follows, i_clk, i_rst_n, w_take && !o_byte.last_byte,
                    o_byte.valid && o_byte.last_byte)
    `GG_ASSERT_IMPL(a_hi_two_byte, i_clk, i_rst_n, r_ovld && r_hi, i_mg > 16'd255)
    `GG_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_rdy && i_vld, r_v[0])
endmodule

// ===== test/gg_encode_checker.sv =====
// Checker for the gray-map gamma encoder: tracks register writes, predicts
// the bytes of every accepted sample and compares them with the output stream.
// Depends on gg_pkg and the channel interfaces gg_cfg_if, gg_sample_if, gg_byte_if.
`timescale 1ns / 1ps
module gg_encode_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gg_cfg_if     cfg_ch,
    gg_sample_if  smp_ch,
    gg_byte_if    byte_ch,
    output int    o_errors,
    output int    o_pending
);
    localparam int FB    = gg_pkg::FRAC_BITS_DEF;
    localparam int DEPTH = gg_pkg::CURVE_DEPTH_DEF;
    localparam longint unsigned UNIT30 = 64'd1 << 30;

    typedef struct {
        longint unsigned m;
        int              e;
    } t_soft_real;

    typedef struct {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       image_end;
    } t_byte_req;

    longint unsigned pow_table [0:DEPTH];
    t_byte_req       byte_fifo [$];
    logic [15:0]     gray_max;
    logic            fmt;

    assign o_pending = byte_fifo.size();

    function automatic t_soft_real sr_norm(longint unsigned m, int e);
        t_soft_real r;
        while (m >= (UNIT30 << 1)) begin
            m = m >> 1;
            e = e + 1;
        end
        while (m < UNIT30) begin
            m = m << 1;
            e = e - 1;
        end
        r.m = m;
        r.e = e;
        return r;
    endfunction

    function automatic t_soft_real sr_times(t_soft_real a, t_soft_real b);
        return sr_norm((a.m * b.m) >> 30, a.e + b.e);
    endfunction

    function automatic t_soft_real sr_ninth(t_soft_real a);
        t_soft_real x2, x4, x8;
        x2 = sr_times(a, a);
        x4 = sr_times(x2, x2);
        x8 = sr_times(x4, x4);
        return sr_times(x8, a);
    endfunction

    function automatic t_soft_real sr_twentieth(t_soft_real a);
        t_soft_real x2, x4, x5, x10;
        x2  = sr_times(a, a);
        x4  = sr_times(x2, x2);
        x5  = sr_times(x4, a);
        x10 = sr_times(x5, x5);
        return sr_times(x10, x10);
    endfunction

    // Build the Q30 table of (k/D)^0.45 by bisection on y^20 <= (k/D)^9
    initial begin
        t_soft_real      d9, rhs, lhs;
        longint unsigned lo, hi, mid;
        d9 = sr_ninth(sr_norm(DEPTH, 30));
        for (int k = 0; k <= DEPTH; k++) begin
            if (k == 0) begin
                pow_table[k] = 0;
            end else if (k == DEPTH) begin
                pow_table[k] = UNIT30;
            end else begin
                rhs = sr_ninth(sr_norm(k, 30));
                lo  = 0;
                hi  = UNIT30;
                while (hi - lo > 1) begin
                    mid = lo + ((hi - lo) >> 1);
                    lhs = sr_times(sr_twentieth(sr_norm(mid, 0)), d9);
                    if (lhs.e < rhs.e || (lhs.e == rhs.e && lhs.m <= rhs.m)) begin
                        lo = mid;
                    end else begin
                        hi = mid;
                    end
                end
                pow_table[k] = lo;
            end
            if (k > 0 && pow_table[k] < pow_table[k-1]) begin
                pow_table[k] = pow_table[k-1];
            end
        end
    end

    // Gamma-encoded output word for one sample
    function automatic longint unsigned gamma_word(logic signed [31:0] s, longint unsigned mg,
                                                   logic f);
        longint          ss;
        longint unsigned one, v, w, p, idx, fr, pw, n, t0, t1;
        ss  = s;
        one = 64'd1 << FB;
        if (ss <= 0) begin
            v = 0;
        end else if (f == gg_pkg::FMT_INT) begin
            v = (ss >= longint'(mg)) ? one : ((unsigned'(ss) << FB) / mg);
        end else begin
            v = (unsigned'(ss) >= one) ? one : unsigned'(ss);
        end
        if (v * 1000 <= 18 * one) begin
            w = (9 * v * mg + one) >> (FB + 1);
        end else begin
            p   = v * DEPTH;
            idx = p >> FB;
            fr  = p & (one - 1);
            if (idx >= DEPTH) begin
                pw = pow_table[DEPTH];
            end else begin
                t0 = pow_table[idx];
                t1 = pow_table[idx+1];
                pw = t0 + (((t1 - t0) * fr) >> FB);
            end
            n = 1099 * pw;
            n = (n <= 99 * UNIT30) ? 0 : n - 99 * UNIT30;
            w = (2 * n * mg + 1000 * UNIT30) / (2000 * UNIT30);
        end
        return (w > mg) ? mg : w;
    endfunction

    always @(posedge i_clk) begin
        longint unsigned mg, w;
        t_byte_req       br, exp_br;
        if (!i_rst_n) begin
            gray_max = gg_pkg::MAX_GRAY_RST;
            fmt      = gg_pkg::FMT_INT;
            o_errors = 0;
            byte_fifo.delete();
        end else begin
            // track register writes
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    gg_pkg::CFG_MAX_GRAY:      gray_max = cfg_ch.data;
                    gg_pkg::CFG_SAMPLE_FORMAT: fmt      = cfg_ch.data[0];
                    default: ;
                endcase
            end
            // predict bytes for each accepted sample
            if (smp_ch.valid && smp_ch.ready) begin
                mg = (gray_max == 0) ? 1 : gray_max;
                w  = gamma_word(smp_ch.sample_value, mg, fmt);
                if (mg > 255) begin
                    br = '{data_byte: w[15:8], last_byte: 1'b0, image_end: 1'b0};
                    byte_fifo.push_back(br);
                end
                br = '{data_byte: w[7:0], last_byte: 1'b1, image_end: smp_ch.final_sample};
                byte_fifo.push_back(br);
            end
            // compare each delivered byte with the oldest prediction
            if (byte_ch.valid && byte_ch.ready) begin
                if (byte_fifo.size() == 0) begin
                    $error("unexpected byte request %0h", byte_ch.data_byte);
                    o_errors++;
                end else begin
                    exp_br = byte_fifo.pop_front();
                    if (byte_ch.data_byte !== exp_br.data_byte) begin
                        $error("data_byte: expected %0h, got %0h", exp_br.data_byte,
                               byte_ch.data_byte);
                        o_errors++;
                    end
                    if (byte_ch.last_byte !== exp_br.last_byte) begin
                        $error("last_byte: expected %0b, got %0b", exp_br.last_byte,
                               byte_ch.last_byte);
                        o_errors++;
                    end
                    if (byte_ch.image_end !== exp_br.image_end) begin
                        $error("image_end: expected %0b, got %0b", exp_br.image_end,
                               byte_ch.image_end);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

// ===== test/testbench.sv =====
// Top of the gray-map gamma encoder bench: clock, reset, register phases,
// sample and byte traffic, timeout and verdict.
// Depends on gg_pkg, the channel interfaces, the core and gg_encode_checker.
`timescale 1ns / 1ps
module testbench;
    localparam logic [gg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;
    localparam int N_PHASES   = 9;
    localparam int RAND_ITEMS = 75;
    localparam int CYCLE_CAP  = 300000;
    localparam int DRAIN      = gg_pkg::FRAC_BITS_DEF + 30;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, cycles;
    logic calm_send, calm_recv;
    logic hold_req;

    gg_cfg_if    cfg_ch ();
    gg_sample_if smp_ch ();
    gg_byte_if   byte_ch ();

    gamma_graymap_pixel_encoder_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_sample (smp_ch),
        .o_byte   (byte_ch)
    );

    gg_encode_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cfg_ch    (cfg_ch),
        .smp_ch    (smp_ch),
        .byte_ch   (byte_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Abort on a hung run
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic int pick_gap(logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus one long hold on request
    initial begin
        int   stall;
        logic held;
        stall = 0;
        held  = 1'b0;
        byte_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                stall = 300;
                held  = 1'b1;
            end else if (stall == 0 && !calm_recv && $urandom_range(0, 3) == 0) begin
                stall = pick_gap(1'b0);
            end
            if (stall > 0) begin
                byte_ch.ready = 1'b0;
                stall--;
            end else begin
                byte_ch.ready = 1'b1;
            end
        end
    end

    // Write one register; called at a falling edge, returns at one
    task automatic write_reg(logic [gg_pkg::CFG_IDX_W-1:0] idx,
                             logic [gg_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Offer one sample request, then idle for a random gap that may be zero
    task automatic send_sample(logic signed [31:0] s, logic fin);
        int gap;
        smp_ch.valid        = 1'b1;
        smp_ch.sample_value = s;
        smp_ch.final_sample = fin;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        gap = pick_gap(calm_send);
        if (gap > 0) begin
            smp_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] rand_sample(logic f, int mg);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom;
        if (f == gg_pkg::FMT_FIXED) begin
            if (r == 2) return $urandom_range(1100, 1260);
            return $urandom_range(0, 65536);
        end
        if (r == 2) return $urandom_range(0, mg / 20 + 2);
        return $urandom_range(0, mg);
    endfunction

    initial begin
        int          ph_gray [N_PHASES] = '{255, 65535, 1, 65535, 0, 1000, 300, 256, 128};
        logic        ph_fmt  [N_PHASES] = '{gg_pkg::FMT_INT, gg_pkg::FMT_FIXED,
                                            gg_pkg::FMT_INT, gg_pkg::FMT_INT,
                                            gg_pkg::FMT_FIXED, gg_pkg::FMT_FIXED,
                                            gg_pkg::FMT_INT, gg_pkg::FMT_FIXED,
                                            gg_pkg::FMT_INT};
        logic signed [31:0] int_dir [9]  = '{0, 255, 256, -5, 1, 4, 5, 128, 254};
        logic signed [31:0] fix_dir [12] = '{0, -1, 32'sh80000000, 32'sh7FFFFFFF, 65536,
                                             65535, 1179, 1180, 1, 32768, 65537, 1181};
        int mg;
        i_rst_n             = 1'b0;
        calm_send           = 1'b0;
        calm_recv           = 1'b0;
        hold_req            = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        smp_ch.valid        = 1'b0;
        smp_ch.sample_value = '0;
        smp_ch.final_sample = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // registers change only with the pipeline empty
            while (pending != 0) @(negedge i_clk);
            repeat (DRAIN) @(negedge i_clk);
            write_reg(gg_pkg::CFG_MAX_GRAY, 16'(ph_gray[ph]));
            write_reg(gg_pkg::CFG_SAMPLE_FORMAT, ph == 1 ? 16'h0003 : 16'(ph_fmt[ph]));
            if (ph == 2) write_reg(CFG_UNUSED, 16'hBEEF);
            mg = (ph_gray[ph] == 0) ? 1 : ph_gray[ph];

            // directed corners
            if (ph == 0) begin
                foreach (int_dir[i]) send_sample(int_dir[i], i == 8);
            end else if (ph == 1) begin
                foreach (fix_dir[i]) send_sample(fix_dir[i], i == 11);
            end

            calm_send = (ph % 3 == 1);
            calm_recv = (ph % 4 == 2);
            if (ph == 3) hold_req = 1'b1;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                send_sample(rand_sample(ph_fmt[ph], mg), $urandom_range(0, 7) == 0);
                if (n == 4) hold_req = 1'b0;
            end
            smp_ch.valid = 1'b0;
        end

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
